FILE: hw/rtl/valid_pixel_box_mean_fill_top_assert.svh
// Assertion macros for the valid-pixel box mean fill block.
// Used by the controller; expects clk and rst in scope.
`ifndef VALID_PIXEL_BOX_MEAN_FILL_TOP_ASSERT_SVH
`define VALID_PIXEL_BOX_MEAN_FILL_TOP_ASSERT_SVH

// same-cycle implication
`define VPBMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VPBMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/vpbmf_pkg.sv
// Package for the valid-pixel box mean fill block: payload types, constants,
// controller command/status structs. No dependencies.
`default_nettype none
package vpbmf_pkg;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_WINDOW_RADIUS = 2;
  localparam int POS_W = 12;
  localparam int MAX_HEIGHT = 2048;
  localparam int MIN_SIDE = 5;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             frame_last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic win_start;
    logic win_run;
    logic div_start;
    logic div_run;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic release_out;
    logic win_last;
    logic div_last;
    logic out_free;
  } ctrl_status_t;
endpackage
`default_nettype wire

FILE: hw/rtl/valid_pixel_box_mean_fill_top.sv
// Valid-pixel box mean fill: top level joining controller and datapath.
// Uses vpbmf_pkg, vpbmf_ctrl, vpbmf_dp.
//
// Input channel in_valid/in_stall carries a pixel item or a drain tick in
// raster order; output channel out_valid/out_stall returns the floor mean of
// the nonzero pixels in the clipped window around each position, with
// frame_last on the final pixel of a frame. Outputs trail input by
// WINDOW_RADIUS rows plus WINDOW_RADIUS columns; drain ticks flush the tail.
// An item with no result passes through accept, step and release check only.
// An item with a result then scans the (2*WINDOW_RADIUS+1)^2 window over the
// line-store read port, runs the restoring divider one quotient bit per sum
// bit (13 sum bits at radius 2), and loads the output register.
// The result sits in an output register; while the receiver stalls, the
// block finishes the next item and holds it until the register frees.
// Configuration writes (cfg_valid/cfg_ready, always ready) set width/height,
// clamp them and restart the frame. Synchronous reset sets 640x480 and
// clears positions; line store contents are not cleared and need not be.
`default_nettype none
module valid_pixel_box_mean_fill_top #(
  parameter int MAX_WIDTH = vpbmf_pkg::DEF_MAX_WIDTH,
  parameter int WINDOW_RADIUS = vpbmf_pkg::DEF_WINDOW_RADIUS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire vpbmf_pkg::in_item_t             in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output vpbmf_pkg::out_item_t                 out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [vpbmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vpbmf_pkg::POS_W-1:0]     cfg_data
);
  import vpbmf_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  vpbmf_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status(status),
    .cmd(cmd)
  );

  vpbmf_dp #(.MAX_WIDTH(MAX_WIDTH), .WINDOW_RADIUS(WINDOW_RADIUS)) u_dp (
    .clk(clk),
    .rst(rst),
    .in_data(in_data),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .status(status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/vpbmf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module vpbmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/vpbmf_ctrl.sv
// Controller state machine: sequences write, release check, window scan,
// divide and output load. Uses vpbmf_pkg and the assertion macro header.
`default_nettype none
module vpbmf_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire vpbmf_pkg::ctrl_status_t status,
  output vpbmf_pkg::ctrl_cmd_t         cmd
);
  import vpbmf_pkg::*;
  `include "valid_pixel_box_mean_fill_top_assert.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STEP  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_WIN   = 3'd3;
  localparam logic [2:0] ST_WACC  = 3'd4;
  localparam logic [2:0] ST_DLOAD = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.release_out) begin
          cmd.win_start = 1'b1;
          state_next = ST_WIN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WIN: begin
        cmd.win_run = 1'b1;
        if (status.win_last) begin
          state_next = ST_WACC;
        end
      end
      ST_WACC: state_next = ST_DLOAD;
      ST_DLOAD: begin
        cmd.div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `VPBMF_ASSERT_NEXT(a_accept_steps, cmd.accept, state == ST_STEP, "accept not followed by step")
  `VPBMF_ASSERT_NOW(a_busy_stalls, state != ST_IDLE, in_stall, "input taken while busy")
  `VPBMF_ASSERT_NEXT(a_load_idles, cmd.load_out, state == ST_IDLE && !in_stall, "no idle after load")
endmodule
`default_nettype wire

FILE: hw/rtl/vpbmf_dp.sv
// Datapath: frame position counters, line store, window accumulator,
// restoring divider and output register. Uses vpbmf_pkg and vpbmf_ram.
`default_nettype none
module vpbmf_dp #(
  parameter int MAX_WIDTH = vpbmf_pkg::DEF_MAX_WIDTH,
  parameter int WINDOW_RADIUS = vpbmf_pkg::DEF_WINDOW_RADIUS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire vpbmf_pkg::in_item_t             in_data,
  input  wire logic                            cfg_we,
  input  wire logic [vpbmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vpbmf_pkg::POS_W-1:0]     cfg_data,
  input  wire vpbmf_pkg::ctrl_cmd_t            cmd,
  output vpbmf_pkg::ctrl_status_t              status,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output vpbmf_pkg::out_item_t                 out_data
);
  import vpbmf_pkg::*;

  localparam int RING = 2 * WINDOW_RADIUS + 1;
  localparam int RING_W = $clog2(RING);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = RING_W + CW;
  localparam int SUM_W = $clog2(255 * RING * RING + 1);
  localparam int CNT_W = $clog2(RING * RING + 1);
  localparam int WC_W = $clog2(RING);
  localparam int DS_W = $clog2(SUM_W + 1);
  localparam int EW = POS_W + 2;

  logic [POS_W-1:0] frame_width, frame_height;
  logic [POS_W-1:0] in_col, in_row, out_col, out_row;
  logic [RING_W-1:0] in_ring, out_ring;
  in_item_t item;
  logic drain;

  logic [WC_W-1:0] wdy, wdx;
  logic rd_use;
  logic [PIX_W-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic rd_in;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;

  logic [SUM_W-1:0] div_q;
  logic [CNT_W:0] div_r;
  logic [DS_W-1:0] div_cnt;

  logic do_pix;
  logic out_last;
  logic release_ok;
  logic [POS_W-1:0] cfg_clamped;

  assign do_pix = (item.req_type == REQ_PIXEL) && (in_row < frame_height);
  assign out_last = (out_row == frame_height - 1'b1) && (out_col == frame_width - 1'b1);

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data < POS_W'(MIN_SIDE)) begin
      cfg_clamped = POS_W'(MIN_SIDE);
    end else if (cfg_index == REG_FRAME_WIDTH && 32'(cfg_data) > MAX_WIDTH) begin
      cfg_clamped = POS_W'(MAX_WIDTH);
    end else if (cfg_index == REG_FRAME_HEIGHT && 32'(cfg_data) > MAX_HEIGHT) begin
      cfg_clamped = POS_W'(MAX_HEIGHT);
    end
  end

  // release check, all in raster positions
  always_comb begin
    logic [EW-1:0] pr, pc, lr, lc, tr, tc, oc;
    logic need_ok, lag_ok, n0;
    n0 = (in_row == '0) && (in_col == '0);
    if (in_col == '0) begin
      pr = EW'(in_row) - 1'b1;
      pc = EW'(frame_width) - 1'b1;
    end else begin
      pr = EW'(in_row);
      pc = EW'(in_col) - 1'b1;
    end
    lr = EW'(out_row) + EW'(WINDOW_RADIUS);
    if (lr > EW'(frame_height) - 1'b1) lr = EW'(frame_height) - 1'b1;
    oc = EW'(out_col) + EW'(WINDOW_RADIUS);
    lc = oc;
    if (lc > EW'(frame_width) - 1'b1) lc = EW'(frame_width) - 1'b1;
    need_ok = (lr < pr) || (lr == pr && lc <= pc);
    if (oc < EW'(frame_width)) begin
      tr = EW'(out_row) + EW'(WINDOW_RADIUS);
      tc = oc;
    end else begin
      tr = EW'(out_row) + EW'(WINDOW_RADIUS + 1);
      tc = oc - EW'(frame_width);
    end
    lag_ok = (tr == pr) && (tc == pc);
    release_ok = !n0 && (out_row < frame_height) && need_ok && (drain || lag_ok);
  end

  assign status.release_out = release_ok;
  assign status.win_last = (wdy == WC_W'(RING - 1)) && (wdx == WC_W'(RING - 1));
  assign status.div_last = (div_cnt == DS_W'(SUM_W - 1));
  assign status.out_free = !out_valid || !out_stall;

  // window read address
  always_comb begin
    int y, x, r;
    y = int'(out_row) + int'(wdy) - WINDOW_RADIUS;
    x = int'(out_col) + int'(wdx) - WINDOW_RADIUS;
    r = int'(out_ring) + int'(wdy) - WINDOW_RADIUS;
    if (r < 0) begin
      r = r + RING;
    end else if (r >= RING) begin
      r = r - RING;
    end
    rd_in = (y >= 0) && (y < int'(frame_height)) && (x >= 0) && (x < int'(frame_width));
    rd_addr = {RING_W'(r), CW'(x)};
  end

  vpbmf_ram #(.WIDTH(PIX_W), .DEPTH(1 << AW)) u_line_store (
    .clk(clk),
    .wr_en(cmd.step && do_pix),
    .wr_addr({in_ring, CW'(in_col)}),
    .wr_data(item.pixel_value),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    logic [CNT_W:0] t;
    if (cmd.accept) item <= in_data;
    if (cmd.step) drain <= !do_pix;

    rd_use <= cmd.win_run && rd_in;
    if (cmd.win_start) begin
      wdy <= '0;
      wdx <= '0;
      sum <= '0;
      cnt <= '0;
    end else begin
      if (cmd.win_run) begin
        if (wdx == WC_W'(RING - 1)) begin
          wdx <= '0;
          wdy <= wdy + 1'b1;
        end else begin
          wdx <= wdx + 1'b1;
        end
      end
      if (rd_use && rd_data != '0) begin
        sum <= sum + SUM_W'(rd_data);
        cnt <= cnt + 1'b1;
      end
    end

    if (cmd.div_start) begin
      div_q <= sum;
      div_r <= '0;
      div_cnt <= '0;
    end else if (cmd.div_run) begin
      t = {div_r[CNT_W-1:0], div_q[SUM_W-1]};
      if (t >= (CNT_W + 1)'(cnt)) begin
        div_r <= t - (CNT_W + 1)'(cnt);
      end else begin
        div_r <= t;
      end
      div_q <= {div_q[SUM_W-2:0], t >= (CNT_W + 1)'(cnt)};
      div_cnt <= div_cnt + 1'b1;
    end

    if (cmd.load_out) begin
      out_data.out_pixel <= (cnt == '0) ? '0 : div_q[PIX_W-1:0];
      out_data.frame_last <= out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= POS_W'(640);
      frame_height <= POS_W'(480);
      in_col <= '0;
      in_row <= '0;
      in_ring <= '0;
      out_col <= '0;
      out_row <= '0;
      out_ring <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) frame_width <= cfg_clamped;
        if (cfg_index == REG_FRAME_HEIGHT) frame_height <= cfg_clamped;
        if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) begin
          in_col <= '0;
          in_row <= '0;
          in_ring <= '0;
          out_col <= '0;
          out_row <= '0;
          out_ring <= '0;
        end
      end else if (cmd.step && do_pix) begin
        if (in_col == frame_width - 1'b1) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
          in_ring <= (in_ring == RING_W'(RING - 1)) ? '0 : in_ring + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end else if (cmd.load_out) begin
        if (out_last) begin
          in_col <= '0;
          in_row <= '0;
          in_ring <= '0;
          out_col <= '0;
          out_row <= '0;
          out_ring <= '0;
        end else if (out_col == frame_width - 1'b1) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
          out_ring <= (out_ring == RING_W'(RING - 1)) ? '0 : out_ring + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire
